// ===== rtl/cpt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and constants for the capture tachometer
// Field widths, register map, queue entry and sequencer state encodings.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int CAP_W    = 16;
  localparam int PERIOD_W = 16;
  localparam int TICK_W   = 20;
  localparam int PPR_W    = 5;
  localparam int DIAM_W   = 12;
  localparam int INTV_W   = 17;
  localparam int OUT_W    = 16;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // divider datapath
  localparam int Q_W      = OUT_W;
  localparam int CNT_W    = $clog2(Q_W);
  localparam int PI_W     = 21;
  localparam int TD_W     = TICK_W + DIAM_W;
  localparam int PROD_W   = TD_W + PI_W;
  localparam int NUM_W    = PROD_W - Q_W;
  localparam int IP_W     = INTV_W + PPR_W;
  localparam int SCALE_W  = 5;
  localparam int DEN_W    = IP_W + SCALE_W;

  // pi in Q16 times 9 (3.6 km/h per m/s over the 0.01 and mm scaling)
  localparam logic [PI_W-1:0]    PI9_Q16       = 21'd1852983;
  localparam logic [SCALE_W-1:0] SPD_DEN_SCALE = 5'd25;
  localparam logic [6:0]         RPM_SCALE     = 7'd60;
  localparam logic [Q_W-1:0]     SAT_VAL       = {Q_W{1'b1}};

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd60000;
  localparam logic [TICK_W-1:0]   TICK_RST   = 20'd10000;
  localparam logic [PPR_W-1:0]    PPR_RST    = 5'd2;
  localparam logic [DIAM_W-1:0]   DIAM_RST   = 12'd500;
  localparam logic [INTV_W-1:0]   MIN_RST    = 17'd1000;

  // power of two
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    REG_PERIOD = 3'd0,
    REG_TICK   = 3'd1,
    REG_PPR    = 3'd2,
    REG_DIAM   = 3'd3,
    REG_MIN    = 3'd4
  } reg_idx_t;

  typedef enum logic {
    OP_CAPTURE = 1'b0,
    OP_WRAP    = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL1,
    B_MUL2,
    B_SAT_RPM,
    B_DIV_RPM,
    B_SAT_SPD,
    B_DIV_SPD,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] timer_period;
    logic [TICK_W-1:0]   tick_rate_hz;
    logic [PPR_W-1:0]    pulses_per_rev;
    logic [DIAM_W-1:0]   wheel_diameter_mm;
    logic [INTV_W-1:0]   min_interval;
  } cfg_t;

  typedef struct packed {
    logic              measured;
    logic [INTV_W-1:0] interval;
    logic              overflow_error;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage : cpt_pkg
`default_nettype wire

// ===== rtl/cpt_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_ifs: event and result channels of the capture tachometer
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface cpt_req_if;
  import cpt_pkg::*;

  logic             valid;
  logic             ready;
  logic             op;
  logic [CAP_W-1:0] capture_value;

  modport source (output valid, op, capture_value, input ready);
  modport sink   (input valid, op, capture_value, output ready);
endinterface : cpt_req_if

interface cpt_rsp_if;
  import cpt_pkg::*;

  logic              valid;
  logic              ready;
  logic              measured;
  logic [INTV_W-1:0] interval_ticks;
  logic [OUT_W-1:0]  rpm;
  logic [OUT_W-1:0]  speed_centi_kmh;
  logic              overflow_error;

  modport source (output valid, measured, interval_ticks, rpm, speed_centi_kmh,
                  overflow_error, input ready);
  modport sink   (input valid, measured, interval_ticks, rpm, speed_centi_kmh,
                  overflow_error, output ready);
endinterface : cpt_rsp_if
`default_nettype wire

// ===== rtl/capture_tachometer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// capture_tachometer_top: wheel tachometer from timer input capture
// Capture and wrap events in, interval, rpm and speed results out.
// ----------------------------------------------------------------------------
// One result per event. The intake stage takes an event every cycle while its
// two-entry job queue has room. A capture that yields a measurement passes
// the arithmetic sequencer through one pop, two multiply stages, then one
// shared 16-step shift-subtract divider run twice (rpm, then speed), each run
// preceded by a saturation check that skips the 16 steps when the result
// saturates, and the load of the output register, which waits for a free slot.
// Wrap events and captures without a measurement go from the pop straight to
// that load. The sequencer finishes one job before it pops the next, so the
// divider sets the sustained rate of measuring captures.
module capture_tachometer_top (
  input  logic                       clk,
  input  logic                       rst,
  cpt_req_if.sink                    req,
  cpt_rsp_if.source                  rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cpt_pkg::ADDR_W-1:0] paddr,
  input  logic [cpt_pkg::DATA_W-1:0] pwdata,
  output logic [cpt_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import cpt_pkg::*;

  cfg_t       cfg;
  fifo_stat_t fifo_stat;
  logic       push;
  job_t       push_job;
  logic       pop;
  job_t       pop_job;

  cpt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_job  (push_job)
  );

  cpt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .pop_job   (pop_job),
    .fifo_stat (fifo_stat)
  );

  cpt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fifo_stat (fifo_stat),
    .pop_job   (pop_job),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule : capture_tachometer_top
`default_nettype wire

// ===== rtl/cpt_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_regs: configuration register file
// APB-style write/read access to the five tachometer settings.
// ----------------------------------------------------------------------------
module cpt_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpt_pkg::ADDR_W-1:0]  paddr,
  input  logic [cpt_pkg::DATA_W-1:0]  pwdata,
  output logic [cpt_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output cpt_pkg::cfg_t               cfg
);
  import cpt_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timer_period      <= PERIOD_RST;
      cfg.tick_rate_hz      <= TICK_RST;
      cfg.pulses_per_rev    <= PPR_RST;
      cfg.wheel_diameter_mm <= DIAM_RST;
      cfg.min_interval      <= MIN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_PERIOD: cfg.timer_period      <= pwdata[PERIOD_W-1:0];
        REG_TICK:   cfg.tick_rate_hz      <= pwdata[TICK_W-1:0];
        REG_PPR:    cfg.pulses_per_rev    <= pwdata[PPR_W-1:0];
        REG_DIAM:   cfg.wheel_diameter_mm <= pwdata[DIAM_W-1:0];
        REG_MIN:    cfg.min_interval      <= pwdata[INTV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PERIOD: prdata = DATA_W'(cfg.timer_period);
      REG_TICK:   prdata = DATA_W'(cfg.tick_rate_hz);
      REG_PPR:    prdata = DATA_W'(cfg.pulses_per_rev);
      REG_DIAM:   prdata = DATA_W'(cfg.wheel_diameter_mm);
      REG_MIN:    prdata = DATA_W'(cfg.min_interval);
      default:    prdata = '0;
    endcase
  end

endmodule : cpt_regs
`default_nettype wire

// ===== rtl/cpt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_front: event intake and interval classification
// Tracks last capture and wrap state, forms the interval, queues a job.
// ----------------------------------------------------------------------------
module cpt_front (
  input  logic                clk,
  input  logic                rst,
  cpt_req_if.sink             req,
  input  cpt_pkg::cfg_t       cfg,
  input  cpt_pkg::fifo_stat_t fifo_stat,
  output logic                push,
  output cpt_pkg::job_t       push_job
);
  import cpt_pkg::*;

  logic [CAP_W-1:0]  last_capture;
  logic [CAP_W-1:0]  last_capture_next;
  logic              have_capture;
  logic              have_capture_next;
  logic              wrapped;
  logic              wrapped_next;
  logic [INTV_W-1:0] base;
  logic [INTV_W-1:0] diff;

  assign req.ready = ~fifo_stat.full;
  assign push      = req.valid & ~fifo_stat.full;

  // modulus is period + 1 since the timer counts 0..period
  assign base = wrapped ? (INTV_W'(cfg.timer_period) + INTV_W'(1)) : '0;
  assign diff = base + INTV_W'(req.capture_value) - INTV_W'(last_capture);

  always_comb begin
    push_job          = '0;
    last_capture_next = last_capture;
    have_capture_next = have_capture;
    wrapped_next      = wrapped;
    if (req.op == OP_CAPTURE) begin
      if (have_capture) begin
        push_job.interval = diff;
        push_job.measured = (diff > cfg.min_interval);
      end
      last_capture_next = req.capture_value;
      have_capture_next = 1'b1;
      wrapped_next      = 1'b0;
    end else begin
      if (wrapped && have_capture) begin
        push_job.overflow_error = 1'b1;
      end else begin
        wrapped_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_capture <= '0;
      have_capture <= 1'b0;
      wrapped      <= 1'b0;
    end else if (push) begin
      last_capture <= last_capture_next;
      have_capture <= have_capture_next;
      wrapped      <= wrapped_next;
    end
  end

endmodule : cpt_front
`default_nettype wire

// ===== rtl/cpt_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_fifo: job queue between intake and arithmetic
// Small register FIFO, FIFO_DEPTH entries.
// ----------------------------------------------------------------------------
module cpt_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cpt_pkg::job_t       push_job,
  input  logic                pop,
  output cpt_pkg::job_t       pop_job,
  output cpt_pkg::fifo_stat_t fifo_stat
);
  import cpt_pkg::*;

  job_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign fifo_stat.full  = (count == (PTR_W + 1)'(FIFO_DEPTH));
  assign fifo_stat.empty = (count == '0);
  assign pop_job         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PTR_W + 1)'(1);
        2'b01:   count <= count - (PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule : cpt_fifo
`default_nettype wire

// ===== rtl/cpt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_back: rpm and speed arithmetic
// Sequencer around two multiply stages and one shared shift-subtract divider
// with early saturation check; results leave through an output register.
// ----------------------------------------------------------------------------
module cpt_back (
  input  logic                clk,
  input  logic                rst,
  input  cpt_pkg::cfg_t       cfg,
  input  cpt_pkg::fifo_stat_t fifo_stat,
  input  cpt_pkg::job_t       pop_job,
  output logic                pop,
  cpt_rsp_if.source           rsp
);
  import cpt_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  logic [CNT_W-1:0]  cnt;
  job_t              job;
  logic [TD_W-1:0]   td;
  logic [IP_W-1:0]   ip;
  logic [PROD_W-1:0] spd_prod;
  logic [NUM_W-1:0]  spd_num;
  logic [DEN_W-1:0]  spd_den;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  rem_next;
  logic [Q_W-1:0]    quo;
  logic [Q_W-1:0]    quo_next;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    trial_diff;
  logic              fits;
  logic              sat_hit;
  logic              last_step;
  logic              slot_free;
  logic              load_out;
  logic [Q_W-1:0]    rpm_q;
  logic [Q_W-1:0]    spd_q;

  logic              out_valid;
  logic              out_measured;
  logic [INTV_W-1:0] out_interval;
  logic [OUT_W-1:0]  out_rpm;
  logic [OUT_W-1:0]  out_speed;
  logic              out_error;

  assign slot_free = ~out_valid | rsp.ready;
  assign last_step = (cnt == CNT_W'(Q_W - 1));

  // quotient overflows 16 bits (or divisor is zero)
  assign sat_hit = ((DEN_W + Q_W)'(num) >= {den, {Q_W{1'b0}}});

  assign trial      = {rem, quo[Q_W-1]};
  assign trial_diff = trial - {1'b0, den};
  assign fits       = (trial >= {1'b0, den});
  assign rem_next   = fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
  assign quo_next   = {quo[Q_W-2:0], fits};

  assign spd_prod = PROD_W'(td) * PROD_W'(PI9_Q16);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:    if (!fifo_stat.empty) begin
                   state_next = pop_job.measured ? B_MUL1 : B_DONE;
                 end
      B_MUL1:    state_next = B_MUL2;
      B_MUL2:    state_next = B_SAT_RPM;
      B_SAT_RPM: state_next = sat_hit ? B_SAT_SPD : B_DIV_RPM;
      B_DIV_RPM: if (last_step) begin
                   state_next = B_SAT_SPD;
                 end
      B_SAT_SPD: state_next = sat_hit ? B_DONE : B_DIV_SPD;
      B_DIV_SPD: if (last_step) begin
                   state_next = B_DONE;
                 end
      B_DONE:    if (slot_free) begin
                   state_next = B_IDLE;
                 end
      default:   state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state)
      B_IDLE:  pop      = ~fifo_stat.empty;
      B_DONE:  load_out = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == B_DIV_RPM || state == B_DIV_SPD) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!fifo_stat.empty) begin
          job   <= pop_job;
          rpm_q <= '0;
          spd_q <= '0;
        end
      end
      B_MUL1: begin
        td <= TD_W'(cfg.tick_rate_hz) * TD_W'(cfg.wheel_diameter_mm);
        ip <= IP_W'(job.interval) * IP_W'(cfg.pulses_per_rev);
      end
      B_MUL2: begin
        spd_num <= spd_prod[PROD_W-1:Q_W];
        spd_den <= DEN_W'(ip) * DEN_W'(SPD_DEN_SCALE);
        num     <= NUM_W'(cfg.tick_rate_hz) * NUM_W'(RPM_SCALE);
        den     <= DEN_W'(ip);
      end
      B_SAT_RPM: begin
        if (sat_hit) begin
          rpm_q <= SAT_VAL;
          num   <= spd_num;
          den   <= spd_den;
        end else begin
          rem <= DEN_W'(num[NUM_W-1:Q_W]);
          quo <= num[Q_W-1:0];
        end
      end
      B_DIV_RPM: begin
        rem <= rem_next;
        quo <= quo_next;
        if (last_step) begin
          rpm_q <= quo_next;
          num   <= spd_num;
          den   <= spd_den;
        end
      end
      B_SAT_SPD: begin
        if (sat_hit) begin
          spd_q <= SAT_VAL;
        end else begin
          rem <= DEN_W'(num[NUM_W-1:Q_W]);
          quo <= num[Q_W-1:0];
        end
      end
      B_DIV_SPD: begin
        rem <= rem_next;
        quo <= quo_next;
        if (last_step) begin
          spd_q <= quo_next;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_measured <= job.measured;
      out_interval <= job.interval;
      out_rpm      <= rpm_q;
      out_speed    <= spd_q;
      out_error    <= job.overflow_error;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.measured        = out_measured;
  assign rsp.interval_ticks  = out_interval;
  assign rsp.rpm             = out_rpm;
  assign rsp.speed_centi_kmh = out_speed;
  assign rsp.overflow_error  = out_error;

`ifndef SYNTHESIS
  a_unmeasured_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.measured |-> rsp.rpm == '0 && rsp.speed_centi_kmh == '0)
    else $error("unmeasured result carries rpm or speed");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.overflow_error |-> !rsp.measured && rsp.interval_ticks == '0)
    else $error("overflow result carries a measurement");

  a_measured_above_min: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.measured |-> rsp.interval_ticks > cfg.min_interval)
    else $error("measurement on interval at or below minimum");
`endif

endmodule : cpt_back
`default_nettype wire

// ===== verif/tb_capture_tachometer_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_capture_tachometer_top: self-checking bench for the capture tachometer
// Capture and wrap events go in as bursts against a result sink that stalls.
// Each result is checked field by field against an in-bench model of the
// interval, rpm and speed arithmetic. Runs a directed set first, then random
// wheel traffic with noise, under several register settings.
// ----------------------------------------------------------------------------
module tb_capture_tachometer_top;
  import cpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int MAX_REPORTS    = 10;
  localparam int REG_COUNT      = 5;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_EVENTS   = 300;
  localparam longint unsigned PI_Q16 = 205887;

  typedef struct packed {
    op_t              op;
    logic [CAP_W-1:0] capture_value;
  } tach_event_t;

  typedef struct packed {
    logic              measured;
    logic [INTV_W-1:0] interval_ticks;
    logic [OUT_W-1:0]  rpm;
    logic [OUT_W-1:0]  speed_centi_kmh;
    logic              overflow_error;
  } tach_reading_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  cpt_req_if req ();
  cpt_rsp_if rsp ();

  capture_tachometer_top dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // model state
  cfg_t             cfg = '{16'd60000, 20'd10000, 5'd2, 12'd500, 17'd1000};
  logic [CAP_W-1:0] last_count   = '0;
  logic             seen_capture = 1'b0;
  logic             wrap_pending = 1'b0;

  tach_event_t   pending_events[$];
  tach_reading_t due_readings[$];
  tach_event_t   cur_event = '0;
  logic          in_flight = 1'b0;
  logic          taken     = 1'b0;
  int            burst_left = 1;
  int            gap_left   = 0;

  logic [15:0]   stall_pat  = '1;
  int unsigned   sink_cycle = 0;
  int unsigned   timer_pos  = 0;
  int            quiet_cycles = 0;

  int mismatches = 0;
  int n_capture = 0, n_wrap = 0, n_measured = 0, n_saturated = 0;
  int n_overflow = 0, n_settings = 1;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [OUT_W-1:0] sat_quotient(longint unsigned num,
                                                    longint unsigned den);
    longint unsigned q;
    if (den == 0)
      return '1;
    q = num / den;
    return (q > 65535) ? '1 : OUT_W'(q);
  endfunction

  function automatic tach_reading_t predict_reading(tach_event_t ev);
    tach_reading_t   r;
    logic [INTV_W-1:0] base;
    longint unsigned den, tick, diam;
    r = '0;
    if (ev.op == OP_CAPTURE) begin
      n_capture++;
      if (seen_capture) begin
        base = wrap_pending ? INTV_W'(cfg.timer_period) + 1'b1 : '0;
        r.interval_ticks = base + ev.capture_value - last_count;
        if (r.interval_ticks > cfg.min_interval) begin
          den  = r.interval_ticks;
          den  = den * cfg.pulses_per_rev;
          tick = cfg.tick_rate_hz;
          diam = cfg.wheel_diameter_mm;
          r.measured        = 1'b1;
          r.rpm             = sat_quotient(tick * 60, den);
          r.speed_centi_kmh = sat_quotient(tick * diam * PI_Q16 * 9, den * 25 * 65536);
          n_measured++;
          if (r.rpm == '1 || r.speed_centi_kmh == '1)
            n_saturated++;
        end
      end
      wrap_pending = 1'b0;
      last_count   = ev.capture_value;
      seen_capture = 1'b1;
    end else begin
      n_wrap++;
      if (wrap_pending && seen_capture) begin
        r.overflow_error = 1'b1;
        n_overflow++;
      end else begin
        wrap_pending = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void store_setting(logic [2:0] idx, logic [DATA_W-1:0] value);
    case (idx)
      REG_PERIOD: cfg.timer_period      = value[PERIOD_W-1:0];
      REG_TICK:   cfg.tick_rate_hz      = value[TICK_W-1:0];
      REG_PPR:    cfg.pulses_per_rev    = value[PPR_W-1:0];
      REG_DIAM:   cfg.wheel_diameter_mm = value[DIAM_W-1:0];
      REG_MIN:    cfg.min_interval      = value[INTV_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string what, tach_reading_t want,
                                        tach_reading_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s | expected m=%0d intv=%0d rpm=%0d spd=%0d err=%0d | got m=%0d intv=%0d rpm=%0d spd=%0d err=%0d",
               $realtime, what, want.measured, want.interval_ticks, want.rpm,
               want.speed_centi_kmh, want.overflow_error, got.measured,
               got.interval_ticks, got.rpm, got.speed_centi_kmh, got.overflow_error);
  endfunction

  // event transfer: predict on acceptance
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      due_readings.push_back(predict_reading(cur_event));
      taken = 1'b1;
    end
  end

  // event driver, bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (taken) begin
        in_flight = 1'b0;
        taken     = 1'b0;
      end
      if (!in_flight && gap_left > 0) begin
        gap_left--;
      end else if (!in_flight && pending_events.size() != 0) begin
        cur_event = pending_events.pop_front();
        in_flight = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 24);
        end
      end
      req.valid         <= in_flight;
      req.op            <= cur_event.op;
      req.capture_value <= cur_event.capture_value;
    end
  end

  // result sink ready, driven from a random stall pattern
  always @(negedge clk) begin
    if (sink_cycle % 64 == 0)
      stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
    rsp.ready <= stall_pat[sink_cycle % 16];
    sink_cycle++;
  end

  always @(posedge clk) begin
    tach_reading_t got, want;
    string         bad;
    if (!rst && rsp.valid && rsp.ready) begin
      got.measured        = rsp.measured;
      got.interval_ticks  = rsp.interval_ticks;
      got.rpm             = rsp.rpm;
      got.speed_centi_kmh = rsp.speed_centi_kmh;
      got.overflow_error  = rsp.overflow_error;
      if (due_readings.size() == 0) begin
        note_mismatch("result with no event outstanding", '0, got);
      end else begin
        want = due_readings.pop_front();
        bad  = "";
        if (got.measured !== want.measured)               bad = {bad, " measured"};
        if (got.interval_ticks !== want.interval_ticks)   bad = {bad, " interval_ticks"};
        if (got.rpm !== want.rpm)                         bad = {bad, " rpm"};
        if (got.speed_centi_kmh !== want.speed_centi_kmh) bad = {bad, " speed_centi_kmh"};
        if (got.overflow_error !== want.overflow_error)   bad = {bad, " overflow_error"};
        if (bad != "")
          note_mismatch({"field mismatch:", bad}, want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, due_readings.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    store_setting(idx, value);
  endtask

  function automatic void add_event(op_t op, logic [CAP_W-1:0] value);
    pending_events.push_back('{op, value});
  endfunction

  task automatic wait_idle();
    while (pending_events.size() != 0 || in_flight || due_readings.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_settings();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(1, 255);
      3: v = $urandom;
      default: v = $urandom_range(256, 65535);
    endcase
    write_reg(REG_PERIOD, v);
    case ($urandom_range(0, 3))
      0: v = $urandom_range(1, 1000);
      3: v = $urandom;
      default: v = $urandom_range(1000, 1000000);
    endcase
    write_reg(REG_TICK, v);
    v = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 16);
    write_reg(REG_PPR, v);
    v = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 4000);
    write_reg(REG_DIAM, v);
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = '1;
      2: v = $urandom_range(0, 64);
      default: v = $urandom_range(0, cfg.timer_period);
    endcase
    write_reg(REG_MIN, v);
    n_settings++;
  endtask

  // pulses from a wheel on a free-running timer, with stray events mixed in
  task automatic wheel_run(int count);
    int unsigned modulus, dt, wraps;
    int          queued;
    modulus   = cfg.timer_period + 1;
    timer_pos = timer_pos % modulus;
    queued    = 0;
    while (queued < count) begin
      case ($urandom_range(0, 9))
        0: begin
          add_event(OP_WRAP, 16'($urandom));
          queued++;
        end
        1: begin
          add_event(OP_CAPTURE, 16'($urandom));
          queued++;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: dt = $urandom_range(1, 64);
            1: begin
              dt = cfg.min_interval + $urandom_range(1, 7);
              if (dt > 4)
                dt -= 4;
            end
            2: dt = $urandom_range(1, modulus);
            default: dt = cfg.min_interval + $urandom_range(1, modulus);
          endcase
          wraps     = (timer_pos + dt) / modulus;
          timer_pos = (timer_pos + dt) % modulus;
          for (int w = 0; w < wraps && w < 3; w++) begin
            add_event(OP_WRAP, 16'($urandom));
            queued++;
          end
          add_event(OP_CAPTURE, 16'(timer_pos));
          queued++;
        end
      endcase
    end
  endtask

  initial begin
    int split;
    req.valid         = 1'b0;
    req.op            = OP_CAPTURE;
    req.capture_value = '0;
    rsp.ready         = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings
    add_event(OP_WRAP, 16'h0000);
    add_event(OP_WRAP, 16'hFFFF);       // still no capture: no flag
    add_event(OP_CAPTURE, 16'h0000);    // first capture only records
    add_event(OP_CAPTURE, 16'hFFFF);    // count past the period
    add_event(OP_CAPTURE, 16'hFFFF);    // zero interval
    add_event(OP_CAPTURE, 16'd1000);    // behind without a wrap
    add_event(OP_CAPTURE, 16'd2000);    // exactly min_interval
    add_event(OP_CAPTURE, 16'd3001);    // one above min_interval
    add_event(OP_WRAP, 16'h5A5A);
    add_event(OP_CAPTURE, 16'd3000);
    add_event(OP_WRAP, 16'h0000);
    add_event(OP_WRAP, 16'h0000);       // double wrap
    add_event(OP_WRAP, 16'h0000);
    add_event(OP_CAPTURE, 16'd0);
    wait_idle();

    // upper extremes
    write_reg(REG_PERIOD, 32'd65535);
    write_reg(REG_TICK, 32'd1000000);
    write_reg(REG_PPR, 32'd1);
    write_reg(REG_DIAM, 32'd4000);
    write_reg(REG_MIN, 32'd0);
    n_settings++;
    add_event(OP_WRAP, 16'h0000);
    add_event(OP_CAPTURE, 16'hFFFF);    // largest interval
    add_event(OP_CAPTURE, 16'hFFFF);
    add_event(OP_CAPTURE, 16'h0000);
    add_event(OP_CAPTURE, 16'h0001);    // one tick: saturates
    wait_idle();

    // zero period and zero pulses, with junk in the upper bits
    write_reg(REG_PERIOD, 32'hFFFF_0000);
    write_reg(REG_TICK, 32'hFFF0_0001);
    write_reg(REG_PPR, 32'hFFFF_FFE0);
    write_reg(REG_DIAM, 32'hFFFF_F001);
    write_reg(REG_MIN, 32'hFFFE_0000);
    for (int k = REG_COUNT; k < 8; k++)
      write_reg(3'(k), '1);
    n_settings++;
    add_event(OP_CAPTURE, 16'd5);
    add_event(OP_WRAP, 16'hFFFF);
    add_event(OP_CAPTURE, 16'd5);
    add_event(OP_WRAP, 16'h0000);
    add_event(OP_WRAP, 16'h0000);
    add_event(OP_CAPTURE, 16'd0);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_settings();
      split = $urandom_range(50, PHASE_EVENTS - 50);
      wheel_run(split);
      wait_idle();                       // hold the sender until all results are back
      wheel_run(PHASE_EVENTS - split);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d events (%0d captures, %0d wraps) over %0d register settings.",
             n_capture + n_wrap, n_capture, n_wrap, n_settings);
    $display("%0d measurements, %0d saturated, %0d overflow flags, %0d mismatches.",
             n_measured, n_saturated, n_overflow, mismatches);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule : tb_capture_tachometer_top
